// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define OWM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one at the next edge.
`define OWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/owm_pkg.sv =====
`default_nettype none

package owm_pkg;

    localparam int CfgW      = 10;
    localparam int TimerBits = 10;
    localparam int CmpW      = (TimerBits > CfgW) ? TimerBits : CfgW;
    localparam int CfgIdxW   = 3;

    // Actions carried by an input request.
    localparam logic [1:0] ActTick  = 2'd0;
    localparam logic [1:0] ActReset = 2'd1;
    localparam logic [1:0] ActWrite = 2'd2;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] RegResetLow  = 3'd0;
    localparam logic [CfgIdxW-1:0] RegResetRel  = 3'd1;
    localparam logic [CfgIdxW-1:0] RegResetTail = 3'd2;
    localparam logic [CfgIdxW-1:0] RegOneLow    = 3'd3;
    localparam logic [CfgIdxW-1:0] RegOneRel    = 3'd4;
    localparam logic [CfgIdxW-1:0] RegZeroLow   = 3'd5;
    localparam logic [CfgIdxW-1:0] RegZeroRel   = 3'd6;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic       line_level;
    } t_in_item;

    typedef struct packed {
        logic drive_low;
        logic busy_res;
        logic done_res;
        logic presence;
    } t_out_item;

    typedef struct packed {
        logic [CfgW-1:0] reset_low_us;
        logic [CfgW-1:0] reset_release_us;
        logic [CfgW-1:0] reset_tail_us;
        logic [CfgW-1:0] one_low_us;
        logic [CfgW-1:0] one_release_us;
        logic [CfgW-1:0] zero_low_us;
        logic [CfgW-1:0] zero_release_us;
    } t_cfg;

    // Saturate to the timer range and stretch zero to one tick.
    function automatic logic [TimerBits-1:0] timer_load(input logic [CfgW-1:0] v);
        logic [CmpW-1:0] wide;
        logic [CmpW-1:0] maxv;
        wide = CmpW'(v);
        maxv = CmpW'({TimerBits{1'b1}});
        if (wide > maxv) begin
            wide = maxv;
        end
        if (wide == '0) begin
            wide = CmpW'(1);
        end
        return TimerBits'(wide);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/owm_cfg_regs.sv =====
`default_nettype none

module owm_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [owm_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [owm_pkg::CfgW-1:0]      i_cfg_data,
    output owm_pkg::t_cfg                      o_cfg
);
    import owm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                RegResetLow:  n_cfg.reset_low_us     = i_cfg_data;
                RegResetRel:  n_cfg.reset_release_us = i_cfg_data;
                RegResetTail: n_cfg.reset_tail_us    = i_cfg_data;
                RegOneLow:    n_cfg.one_low_us       = i_cfg_data;
                RegOneRel:    n_cfg.one_release_us   = i_cfg_data;
                RegZeroLow:   n_cfg.zero_low_us      = i_cfg_data;
                RegZeroRel:   n_cfg.zero_release_us  = i_cfg_data;
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_us     <= CfgW'(480);
            r_cfg.reset_release_us <= CfgW'(70);
            r_cfg.reset_tail_us    <= CfgW'(410);
            r_cfg.one_low_us       <= CfgW'(6);
            r_cfg.one_release_us   <= CfgW'(64);
            r_cfg.zero_low_us      <= CfgW'(60);
            r_cfg.zero_release_us  <= CfgW'(10);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/owm_seq.sv =====
`default_nettype none

module owm_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire owm_pkg::t_in_item  i_item,
    input  wire owm_pkg::t_cfg      i_cfg,
    output owm_pkg::t_out_item      o_res
);
    import owm_pkg::*;

    localparam logic [2:0] PhIdle    = 3'd0;
    localparam logic [2:0] PhRstLow  = 3'd1;
    localparam logic [2:0] PhRstRel  = 3'd2;
    localparam logic [2:0] PhRstTail = 3'd3;
    localparam logic [2:0] PhBitLow  = 3'd4;
    localparam logic [2:0] PhBitRel  = 3'd5;

    logic [2:0]           r_phase, n_phase;
    logic [TimerBits-1:0] r_timer, n_timer;
    logic [2:0]           r_bit, n_bit;
    logic [7:0]           r_shift, n_shift;
    logic                 r_presence, n_presence;
    logic                 done;
    logic [7:0]           next_shift;

    assign next_shift = {1'b0, r_shift[7:1]};

    always_comb begin
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_presence = r_presence;
        done       = 1'b0;
        if (i_step) begin
            if (r_phase == PhIdle) begin
                if (i_item.action == ActReset) begin
                    n_presence = 1'b0;
                    n_phase    = PhRstLow;
                    n_timer    = timer_load(i_cfg.reset_low_us);
                end else if (i_item.action == ActWrite) begin
                    n_shift = i_item.data_byte;
                    n_bit   = 3'd0;
                    n_phase = PhBitLow;
                    n_timer = timer_load(i_item.data_byte[0] ? i_cfg.one_low_us
                                                             : i_cfg.zero_low_us);
                end
            end else if (i_item.action == ActTick) begin
                if (r_timer > TimerBits'(1)) begin
                    n_timer = r_timer - TimerBits'(1);
                end else begin
                    case (r_phase)
                        PhRstLow: begin
                            n_phase = PhRstRel;
                            n_timer = timer_load(i_cfg.reset_release_us);
                        end
                        PhRstRel: begin
                            n_presence = !i_item.line_level;
                            n_phase    = PhRstTail;
                            n_timer    = timer_load(i_cfg.reset_tail_us);
                        end
                        PhRstTail: begin
                            n_phase = PhIdle;
                            n_timer = '0;
                            done    = 1'b1;
                        end
                        PhBitLow: begin
                            n_phase = PhBitRel;
                            n_timer = timer_load(r_shift[0] ? i_cfg.one_release_us
                                                            : i_cfg.zero_release_us);
                        end
                        PhBitRel: begin
                            if (r_bit == 3'd7) begin
                                n_phase = PhIdle;
                                n_timer = '0;
                                n_bit   = 3'd0;
                                done    = 1'b1;
                            end else begin
                                n_bit   = r_bit + 3'd1;
                                n_shift = next_shift;
                                n_phase = PhBitLow;
                                n_timer = timer_load(next_shift[0] ? i_cfg.one_low_us
                                                                   : i_cfg.zero_low_us);
                            end
                        end
                        default: begin
                            n_phase = PhIdle;
                            n_timer = '0;
                        end
                    endcase
                end
            end
        end
    end

    assign o_res.drive_low = (n_phase == PhRstLow) || (n_phase == PhBitLow);
    assign o_res.busy_res  = (n_phase != PhIdle);
    assign o_res.done_res  = done;
    assign o_res.presence  = n_presence;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PhIdle;
            r_timer    <= '0;
            r_bit      <= 3'd0;
            r_presence <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_timer    <= n_timer;
            r_bit      <= n_bit;
            r_presence <= n_presence;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
    end

`include "assert_macros.svh"

    `OWM_ASSERT(a_idle_timer_clear, i_clk, i_rst_n, (r_phase == PhIdle) == (r_timer == '0), "timer and idle phase disagree")
    `OWM_ASSERT(a_bit_only_in_write, i_clk, i_rst_n, (r_bit == 3'd0) || (r_phase == PhBitLow) || (r_phase == PhBitRel), "bit index set outside a byte write")
    `OWM_ASSERT_NEXT(a_reset_clears_presence, i_clk, i_rst_n, i_step && (r_phase == PhIdle) && (i_item.action == ActReset), !r_presence && (r_phase == PhRstLow), "reset start did not clear presence")

endmodule

`default_nettype wire

// ===== rtl/core/onewire_master_reset_and_write_unit.sv =====
// 1-Wire bus master timing sequencer: bus reset with presence detect and
// byte write, paced by one-microsecond tick requests.
// Input channel (i_in_valid / o_in_stall, payload i_in_item): each request is
// a tick, a start-reset command or a start-byte-write command with its byte
// and the sampled line level. Commands that arrive while busy are dropped.
// Output channel (o_out_valid / i_out_stall, payload o_out_item): exactly one
// result per request, giving line drive, busy, done and presence after the
// request has been applied.
// Result: registered, valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless stalled; the sequencer update is one
// pass of logic from the accepted request to the state and result registers.
// Stall: a held result does not block acceptance when the result register
// drains in the same cycle; o_in_stall rises only while a result waits under
// i_out_stall.
// Configuration (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data): seven
// timing registers in microseconds, always ready; write only while idle.
// Reset: synchronous active-low i_rst_n returns the phase to idle, clears
// presence and the result valid flag, and loads the default timing values.
`default_nettype none

module onewire_master_reset_and_write_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire owm_pkg::t_in_item             i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output owm_pkg::t_out_item                 o_out_item,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [owm_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [owm_pkg::CfgW-1:0]      i_cfg_data
);
    import owm_pkg::*;

    t_cfg      cfg;
    t_out_item res;
    logic      in_accept;
    logic      cfg_write;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item;

    // Hold off new requests only while a finished result is stuck downstream.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign cfg_write  = i_cfg_valid && o_cfg_ready;

    owm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_write),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Advance the sequencer only on an accepted request.
    owm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_accept),
        .i_item  (i_in_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Result register: load on accept, drop once taken.
    always_comb begin
        if (in_accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`include "assert_macros.svh"

    `OWM_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, in_accept, o_out_valid, "accepted request produced no result")
    `OWM_ASSERT(a_done_not_busy, i_clk, i_rst_n, !(o_out_valid && o_out_item.done_res && o_out_item.busy_res), "done result still reports busy")
    `OWM_ASSERT(a_drive_needs_busy, i_clk, i_rst_n, !(o_out_valid && o_out_item.drive_low && !o_out_item.busy_res), "line driven low while idle")

endmodule

`default_nettype wire
